// ===== rtl/isff_pkg.sv =====
package isff_pkg;

  // Default pattern capacity in bytes
  localparam int PatternBytesDefault = 8;
  // The search window never exceeds this many bytes
  localparam int WindowMaxBytes = 8;

  // Configuration register indexes
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgSourceAddress   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgWantedPort      = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgMatchAllPayload = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgPatternBytes    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgPatternLength   = 3'd4;

  // Verdict codes
  localparam logic [2:0] VerdictOk        = 3'd0;
  localparam logic [2:0] VerdictNotV4     = 3'd1;
  localparam logic [2:0] VerdictSrcDiff   = 3'd2;
  localparam logic [2:0] VerdictNotTcp    = 3'd3;
  localparam logic [2:0] VerdictPortDiff  = 3'd4;
  localparam logic [2:0] VerdictNoPattern = 3'd5;
  localparam logic [2:0] VerdictTrunc     = 3'd6;

  // Header constants
  localparam logic [3:0]  IpVersion4   = 4'd4;
  localparam logic [7:0]  ProtoTcp     = 8'd6;
  localparam logic [3:0]  MinHdrWords  = 4'd5;
  localparam logic [15:0] PosVerIhl    = 16'd0;
  localparam logic [15:0] PosProto     = 16'd9;
  localparam logic [15:0] PosSrcFirst  = 16'd12;
  localparam logic [15:0] PosSrcLast   = 16'd15;
  localparam logic [15:0] RelDportLast = 16'd3;
  localparam logic [15:0] RelDataOff   = 16'd12;
  localparam logic [5:0]  IpHdrEndReset     = 6'd20;
  localparam logic [6:0]  PayloadStartReset = 7'd40;

  typedef struct packed {
    logic [31:0] source_address;
    logic [15:0] wanted_port;
    logic        match_all_payload;
    logic [63:0] pattern_bytes;
    logic [3:0]  pattern_length;
  } cfg_t;

  typedef struct packed {
    logic        accepted;
    logic [2:0]  verdict;
    logic [15:0] seen_source_port;
    logic [15:0] seen_dest_port;
    logic [15:0] payload_length;
  } res_t;

  typedef struct packed {
    logic step;   // payload byte enters the window
    logic clear;  // end of packet
  } win_ctrl_t;

endpackage

// ===== rtl/isff_window.sv =====
module isff_window #(
  parameter int PATTERN_BYTES = isff_pkg::PatternBytesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  isff_pkg::win_ctrl_t ctrl_i,
  input  logic [7:0]          byte_i,
  input  logic [63:0]         pattern_i,
  input  logic [3:0]          length_i,
  output logic                found_o
);

  localparam int WinBytes = (PATTERN_BYTES < isff_pkg::WindowMaxBytes) ?
                            PATTERN_BYTES : isff_pkg::WindowMaxBytes;
  localparam int FillW = $clog2(WinBytes + 1);

  logic [WinBytes*8-1:0] win_q, win_d;
  logic [FillW-1:0]      fill_q, fill_d;
  logic                  found_q;
  logic [FillW-1:0]      used_len;
  logic                  all_ok;
  logic                  hit;

  // pattern length clamped to window size
  assign used_len = (length_i > 4'(WinBytes)) ? FillW'(WinBytes) : length_i[FillW-1:0];

  always_comb begin
    win_d[7:0] = byte_i;
    for (int k = 1; k < WinBytes; k++) begin
      win_d[k*8 +: 8] = win_q[(k-1)*8 +: 8];
    end
  end

  assign fill_d = (fill_q < FillW'(WinBytes)) ? fill_q + FillW'(1) : fill_q;

  // low byte is the newest, compared with the last pattern byte
  always_comb begin
    all_ok = 1'b1;
    for (int k = 0; k < WinBytes; k++) begin
      if ((k < int'(used_len)) && (win_d[k*8 +: 8] != pattern_i[k*8 +: 8])) begin
        all_ok = 1'b0;
      end
    end
  end

  assign hit     = (used_len != '0) && (fill_d >= used_len) && all_ok;
  assign found_o = found_q | (ctrl_i.step & hit);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step) begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      found_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      fill_q  <= '0;
      found_q <= 1'b0;
    end else if (ctrl_i.step) begin
      fill_q  <= fill_d;
      found_q <= found_o;
    end
  end

endmodule

// ===== rtl/isff_parser.sv =====
module isff_parser #(
  parameter int PATTERN_BYTES = isff_pkg::PatternBytesDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  logic [7:0]     byte_i,
  input  logic           final_i,
  input  isff_pkg::cfg_t cfg_i,
  output isff_pkg::res_t res_o
);

  logic [15:0] pos_q, pos_d;
  logic [5:0]  ihe_q, ihe_d;
  logic [6:0]  ps_q, ps_d;
  logic [23:0] addr_q;
  logic [2:0]  ff_q, ff_d;
  logic [15:0] sport_q, sport_d;
  logic [15:0] dport_q, dport_d;

  logic [3:0]  ihl;
  logic [3:0]  off;
  logic [2:0]  code;
  logic        in_tcp;
  logic [15:0] rel;
  logic [16:0] p_ext;
  logic        past_hdr;
  logic        header_done;
  logic [16:0] plen;
  logic        found;
  logic [2:0]  verdict;
  isff_pkg::win_ctrl_t win_ctrl;

  assign p_ext = {1'b0, pos_q};

  always_comb begin
    ihl   = (byte_i[3:0] < isff_pkg::MinHdrWords) ? isff_pkg::MinHdrWords : byte_i[3:0];
    off   = (byte_i[7:4] < isff_pkg::MinHdrWords) ? isff_pkg::MinHdrWords : byte_i[7:4];
    ihe_d = (pos_q == isff_pkg::PosVerIhl) ? {ihl, 2'b00} : ihe_q;
    code  = isff_pkg::VerdictOk;
    if ((pos_q == isff_pkg::PosVerIhl) && (byte_i[7:4] != isff_pkg::IpVersion4)) begin
      code = isff_pkg::VerdictNotV4;
    end
    if ((pos_q == isff_pkg::PosProto) && (byte_i != isff_pkg::ProtoTcp)) begin
      code = isff_pkg::VerdictNotTcp;
    end
    if ((pos_q == isff_pkg::PosSrcLast) && ({addr_q, byte_i} != cfg_i.source_address)) begin
      code = isff_pkg::VerdictSrcDiff;
    end

    in_tcp  = p_ext >= 17'(ihe_d);
    rel     = pos_q - 16'(ihe_d);
    sport_d = sport_q;
    dport_d = dport_q;
    ps_d    = ps_q;
    if (in_tcp) begin
      if (rel < 16'd2) begin
        sport_d = {sport_q[7:0], byte_i};
      end else if (rel < 16'd4) begin
        dport_d = {dport_q[7:0], byte_i};
        if ((rel == isff_pkg::RelDportLast) && (cfg_i.wanted_port != 16'd0) &&
            (dport_d != cfg_i.wanted_port)) begin
          code = isff_pkg::VerdictPortDiff;
        end
      end else if (rel == isff_pkg::RelDataOff) begin
        ps_d = {1'b0, ihe_d} + {1'b0, off, 2'b00};
      end
    end

    // lowest failure code wins
    ff_d = ((code != isff_pkg::VerdictOk) &&
            ((ff_q == isff_pkg::VerdictOk) || (code < ff_q))) ? code : ff_q;

    past_hdr    = p_ext > (17'(ihe_d) + 17'd12);
    header_done = past_hdr && ((p_ext + 17'd1) >= 17'(ps_d));
    plen        = header_done ? (p_ext + 17'd1 - 17'(ps_d)) : 17'd0;
  end

  assign win_ctrl.step  = fire_i && past_hdr && (p_ext >= 17'(ps_d));
  assign win_ctrl.clear = fire_i && final_i;

  isff_window #(
    .PATTERN_BYTES(PATTERN_BYTES)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (win_ctrl),
    .byte_i   (byte_i),
    .pattern_i(cfg_i.pattern_bytes),
    .length_i (cfg_i.pattern_length),
    .found_o  (found)
  );

  always_comb begin
    priority if (ff_d != isff_pkg::VerdictOk) begin
      verdict = ff_d;
    end else if (!header_done) begin
      verdict = isff_pkg::VerdictTrunc;
    end else if (!cfg_i.match_all_payload && (cfg_i.pattern_length != 4'd0) && !found) begin
      verdict = isff_pkg::VerdictNoPattern;
    end else begin
      verdict = isff_pkg::VerdictOk;
    end
  end

  assign res_o.accepted         = (verdict == isff_pkg::VerdictOk);
  assign res_o.verdict          = verdict;
  assign res_o.seen_source_port = (p_ext >= (17'(ihe_d) + 17'd1)) ? sport_d : 16'd0;
  assign res_o.seen_dest_port   = (p_ext >= (17'(ihe_d) + 17'd3)) ? dport_d : 16'd0;
  assign res_o.payload_length   = plen[15:0];

  assign pos_d = (pos_q != 16'hffff) ? pos_q + 16'd1 : pos_q;

  always_ff @(posedge clk_i) begin
    if (fire_i && (pos_q >= isff_pkg::PosSrcFirst) && (pos_q < isff_pkg::PosSrcLast)) begin
      addr_q <= {addr_q[15:0], byte_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      ihe_q   <= isff_pkg::IpHdrEndReset;
      ps_q    <= isff_pkg::PayloadStartReset;
      ff_q    <= isff_pkg::VerdictOk;
      sport_q <= '0;
      dport_q <= '0;
    end else if (fire_i) begin
      if (final_i) begin
        pos_q   <= '0;
        ihe_q   <= isff_pkg::IpHdrEndReset;
        ps_q    <= isff_pkg::PayloadStartReset;
        ff_q    <= isff_pkg::VerdictOk;
        sport_q <= '0;
        dport_q <= '0;
      end else begin
        pos_q   <= pos_d;
        ihe_q   <= ihe_d;
        ps_q    <= ps_d;
        ff_q    <= ff_d;
        sport_q <= sport_d;
        dport_q <= dport_d;
      end
    end
  end

endmodule

// ===== rtl/ipv4_tcp_sniff_filter.sv =====
// A byte accepted is held in the input register and processed from there;
// for a final byte its verdict is loaded into the output register once that
// register is free, and shows at the outputs from there.
// Throughput: one byte per cycle; only a stalled verdict, waiting in the
// output register while another final byte is ready, holds the input.
// Reset (rst_ni, async, active low) clears the packet state, the output valid
// and the configuration (match-all on, everything else zero).
module ipv4_tcp_sniff_filter #(
  parameter int PATTERN_BYTES = isff_pkg::PatternBytesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // byte input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    packet_byte_i,
  input  logic                          final_byte_i,
  // verdict output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          accepted_o,
  output logic [2:0]                    verdict_o,
  output logic [15:0]                   seen_source_port_o,
  output logic [15:0]                   seen_dest_port_o,
  output logic [15:0]                   payload_length_o,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [isff_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [63:0]                   cfg_data_i
);

  isff_pkg::cfg_t cfg_q;

  // input register
  logic       v1_q;
  logic [7:0] byte1_q;
  logic       final1_q;

  // result register
  logic           ov_q;
  isff_pkg::res_t res_q;
  isff_pkg::res_t res_comb;

  logic out_free;
  logic s1_fire;
  logic in_xfer;

  // Config writes always taken (no check); user must write only while idle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_address    <= '0;
      cfg_q.wanted_port       <= '0;
      cfg_q.match_all_payload <= 1'b1;
      cfg_q.pattern_bytes     <= '0;
      cfg_q.pattern_length    <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        isff_pkg::CfgSourceAddress:   cfg_q.source_address    <= cfg_data_i[31:0];
        isff_pkg::CfgWantedPort:      cfg_q.wanted_port       <= cfg_data_i[15:0];
        isff_pkg::CfgMatchAllPayload: cfg_q.match_all_payload <= cfg_data_i[0];
        isff_pkg::CfgPatternBytes:    cfg_q.pattern_bytes     <= cfg_data_i;
        isff_pkg::CfgPatternLength:   cfg_q.pattern_length    <= cfg_data_i[3:0];
        default: begin
          // unknown index: no register
        end
      endcase
    end
  end

  // Output register is free when empty or when its verdict leaves this cycle.
  assign out_free = !ov_q || !out_stall_i;
  // A non-final byte never needs the output register.
  assign s1_fire  = v1_q && (!final1_q || out_free);
  assign in_stall_o = v1_q && !s1_fire;
  assign in_xfer  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (in_xfer) begin
      v1_q <= 1'b1;
    end else if (s1_fire) begin
      v1_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      byte1_q  <= packet_byte_i;
      final1_q <= final_byte_i;
    end
  end

  // header unpack, filter tests and payload search
  isff_parser #(
    .PATTERN_BYTES(PATTERN_BYTES)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (s1_fire),
    .byte_i (byte1_q),
    .final_i(final1_q),
    .cfg_i  (cfg_q),
    .res_o  (res_comb)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (out_free) begin
      ov_q <= s1_fire && final1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_fire && final1_q) begin
      res_q <= res_comb;
    end
  end

  assign out_valid_o        = ov_q;
  assign accepted_o         = res_q.accepted;
  assign verdict_o          = res_q.verdict;
  assign seen_source_port_o = res_q.seen_source_port;
  assign seen_dest_port_o   = res_q.seen_dest_port;
  assign payload_length_o   = res_q.payload_length;

endmodule

// ===== verif/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import isff_pkg::*;

  // Packet geometry and run limits
  localparam int PatternCap   = PatternBytesDefault;
  localparam int SettleCycles = 4;
  localparam int HoldCycles   = 400;      // long receiver hold-off
  localparam int CycleLimit   = 1000000;
  localparam int MaxReported  = 10;

  // ---------------------------------------------------------------------------
  // Verdict predictor and scoreboard. Mirrors the config registers and the
  // per-packet header/payload state; one expected verdict per final byte.
  // ---------------------------------------------------------------------------
  class verdict_scoreboard;
    logic [31:0] src_addr;
    logic [15:0] want_port;
    logic        match_all;
    logic [63:0] pat;
    logic [3:0]  pat_len;

    logic [15:0] pos;
    logic [5:0]  ip_end;
    logic [6:0]  pl_start;
    logic [31:0] src_shift;
    logic [2:0]  fail_code;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [63:0] window;
    logic [3:0]  fill;
    bit          found;

    res_t        expected_q[$];
    int unsigned mismatches;

    function new();
      src_addr   = '0;
      want_port  = '0;
      match_all  = 1'b1;
      pat        = '0;
      pat_len    = '0;
      mismatches = 0;
      clear_packet();
    endfunction

    function void clear_packet();
      pos       = '0;
      ip_end    = IpHdrEndReset;
      pl_start  = PayloadStartReset;
      src_shift = '0;
      fail_code = VerdictOk;
      sport     = '0;
      dport     = '0;
      window    = '0;
      fill      = '0;
      found     = 1'b0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [63:0] d);
      case (idx)
        CfgSourceAddress:   src_addr  = d[31:0];
        CfgWantedPort:      want_port = d[15:0];
        CfgMatchAllPayload: match_all = d[0];
        CfgPatternBytes:    pat       = d;
        CfgPatternLength:   pat_len   = d[3:0];
        default: ;
      endcase
    endfunction

    // pattern bytes actually compared
    function int unsigned used_len();
      int unsigned n;
      n = pat_len;
      if (n > PatternCap) n = PatternCap;
      if (n > WindowMaxBytes) n = WindowMaxBytes;
      return n;
    endfunction

    // lowest failure code wins regardless of arrival order
    function void note_fail(logic [2:0] code);
      if (fail_code == VerdictOk || code < fail_code) fail_code = code;
    endfunction

    function void note_byte(logic [7:0] b, logic fin);
      int unsigned p, rel, n, plen, hdr_words;
      logic [63:0] mask;
      logic [2:0]  code;
      bit          hdr_done;
      res_t        r;
      p = pos;
      if (p == PosVerIhl) begin
        hdr_words = b[3:0];
        if (b[7:4] != IpVersion4) note_fail(VerdictNotV4);
        if (hdr_words < MinHdrWords) hdr_words = MinHdrWords;
        ip_end = 6'(hdr_words * 4);
      end
      if (p == PosProto && b != ProtoTcp) note_fail(VerdictNotTcp);
      if (p >= PosSrcFirst && p <= PosSrcLast) begin
        src_shift = {src_shift[23:0], b};
        if (p == PosSrcLast && src_shift != src_addr) note_fail(VerdictSrcDiff);
      end
      if (p >= ip_end) begin
        rel = p - ip_end;
        if (rel < 2) begin
          sport = {sport[7:0], b};
        end else if (rel < 4) begin
          dport = {dport[7:0], b};
          if (rel == RelDportLast && want_port != 0 && dport != want_port)
            note_fail(VerdictPortDiff);
        end else if (rel == RelDataOff) begin
          hdr_words = b[7:4];
          if (hdr_words < MinHdrWords) hdr_words = MinHdrWords;
          pl_start = 7'(ip_end + hdr_words * 4);
        end
      end
      // payload search window
      if (p > ip_end + RelDataOff && p >= pl_start) begin
        n = used_len();
        mask = (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
        window = {window[55:0], b};
        if (fill < WindowMaxBytes) fill++;
        if (n > 0 && fill >= n && ((window ^ pat) & mask) == '0) found = 1'b1;
      end

      if (!fin) begin
        if (pos != 16'hffff) pos++;
        return;
      end

      hdr_done = (p > ip_end + RelDataOff) && (p + 1 >= pl_start);
      plen = 0;
      if (hdr_done) begin
        plen = p + 1 - pl_start;
        if (plen > 65535) plen = 65535;
      end
      if (fail_code != VerdictOk)                            code = fail_code;
      else if (!hdr_done)                                    code = VerdictTrunc;
      else if (!match_all && used_len() != 0 && !found)      code = VerdictNoPattern;
      else                                                   code = VerdictOk;

      r.accepted         = (code == VerdictOk);
      r.verdict          = code;
      r.seen_source_port = (p >= ip_end + 1) ? sport : 16'd0;
      r.seen_dest_port   = (p >= ip_end + 3) ? dport : 16'd0;
      r.payload_length   = plen[15:0];
      expected_q.push_back(r);
      clear_packet();
    endfunction

    function void check_verdict(res_t got);
      res_t exp_r;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("%0t: unexpected verdict acc=%0d v=%0d sp=%0d dp=%0d len=%0d", $realtime,
                   got.accepted, got.verdict, got.seen_source_port, got.seen_dest_port,
                   got.payload_length);
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.accepted !== exp_r.accepted || got.verdict !== exp_r.verdict ||
          got.seen_source_port !== exp_r.seen_source_port ||
          got.seen_dest_port !== exp_r.seen_dest_port ||
          got.payload_length !== exp_r.payload_length) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display({"%0t: verdict mismatch exp acc=%0d v=%0d sp=%0d dp=%0d len=%0d",
                    " | got acc=%0d v=%0d sp=%0d dp=%0d len=%0d"},
                   $realtime, exp_r.accepted, exp_r.verdict, exp_r.seen_source_port,
                   exp_r.seen_dest_port, exp_r.payload_length, got.accepted, got.verdict,
                   got.seen_source_port, got.seen_dest_port, got.payload_length);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT signals
  // ---------------------------------------------------------------------------
  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [7:0]         packet_byte_i;
  logic               final_byte_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               accepted_o;
  logic [2:0]         verdict_o;
  logic [15:0]        seen_source_port_o;
  logic [15:0]        seen_dest_port_o;
  logic [15:0]        payload_length_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [63:0]        cfg_data_i;

  verdict_scoreboard sb = new();

  // stimulus bookkeeping
  logic [7:0]  pkt_bytes[$];
  int unsigned bytes_sent;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_request;
  logic        hold_on;
  int unsigned cycle_count;

  ipv4_tcp_sniff_filter uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .packet_byte_i      (packet_byte_i),
    .final_byte_i       (final_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .accepted_o         (accepted_o),
    .verdict_o          (verdict_o),
    .seen_source_port_o (seen_source_port_o),
    .seen_dest_port_o   (seen_dest_port_o),
    .payload_length_o   (payload_length_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Monitor: sample at the rising edge, before any driver update lands.
  // Verdicts are checked before the byte of the same edge is noted; a verdict
  // can never belong to a byte taken at the same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        sb.check_verdict('{accepted_o, verdict_o, seen_source_port_o, seen_dest_port_o,
                           payload_length_o});
      if (in_valid_i && !in_stall_o)
        sb.note_byte(packet_byte_i, final_byte_i);
    end
  end

  // Receiver back-pressure: random stall plus the long hold-off window.
  always @(posedge clk_i)
    out_stall_i <= hold_on || ($urandom_range(0, 99) < recv_idle_pct);

  // Long hold-off, counted here so the sender keeps offering bytes meanwhile.
  initial begin
    hold_on = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_on <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_on <= 1'b0;
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // One byte transfer; random gaps before it. Returns at the accepting edge with
  // valid still high, so a following byte can go out back to back.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i    <= 1'b1;
    packet_byte_i <= b;
    final_byte_i  <= fin;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_packet();
    foreach (pkt_bytes[i]) send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    bytes_sent += pkt_bytes.size();
  endtask

  // Let the byte stream stop and every verdict come out before touching config.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write all five registers back to back; only called while the block is idle.
  task automatic load_setting(input logic [31:0] src, input logic [15:0] port,
                              input logic mall, input logic [63:0] patv,
                              input logic [3:0] plen);
    logic [CfgIdxW-1:0] idx_list[5];
    logic [63:0]        val_list[5];
    idx_list = '{CfgSourceAddress, CfgWantedPort, CfgMatchAllPayload, CfgPatternBytes,
                 CfgPatternLength};
    val_list = '{{32'd0, src}, {48'd0, port}, {63'd0, mall}, patv, {60'd0, plen}};
    for (int i = 0; i < 5; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx_list[i];
      cfg_data_i  <= val_list[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.set_reg(idx_list[i], val_list[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Build an IPv4/TCP packet into pkt_bytes. Unlisted header bytes are random.
  // plant_ofs < 0: no pattern planted; cut > 0: truncate to that many bytes.
  function automatic void make_packet(input logic [3:0] ver, input logic [3:0] ihl,
                                      input logic [7:0] proto, input logic [31:0] src,
                                      input logic [15:0] dp, input logic [3:0] doff,
                                      input int plen, input int plant_ofs, input int cut);
    int ip_len, tcp_len, n, ofs, pl_base;
    logic [7:0] keep;
    pkt_bytes.delete();
    ip_len  = (ihl < MinHdrWords) ? 20 : ihl * 4;
    tcp_len = (doff < MinHdrWords) ? 20 : doff * 4;
    repeat (ip_len + tcp_len + plen) pkt_bytes.push_back(8'($urandom_range(0, 255)));
    pkt_bytes[0]  = {ver, ihl};
    pkt_bytes[9]  = proto;
    pkt_bytes[12] = src[31:24];
    pkt_bytes[13] = src[23:16];
    pkt_bytes[14] = src[15:8];
    pkt_bytes[15] = src[7:0];
    pkt_bytes[ip_len + 2] = dp[15:8];
    pkt_bytes[ip_len + 3] = dp[7:0];
    keep = pkt_bytes[ip_len + 12];
    pkt_bytes[ip_len + 12] = {doff, keep[3:0]};
    n = sb.used_len();
    pl_base = ip_len + tcp_len;
    if (plant_ofs >= 0 && n > 0 && plen >= n) begin
      ofs = (plant_ofs > plen - n) ? plen - n : plant_ofs;
      // first pattern byte sits in the top byte of the used part
      for (int k = 0; k < n; k++) pkt_bytes[pl_base + ofs + k] = sb.pat[8 * (n - 1 - k) +: 8];
    end
    if (cut > 0)
      while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
  endfunction

  function automatic void make_noise(input int len);
    pkt_bytes.delete();
    repeat (len) pkt_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Mostly well-formed packets aimed at the current setting, some truncated,
  // some pure noise.
  task automatic random_packet();
    int kind, plen, plant, cut;
    logic [3:0]  ver, ihl, doff;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [15:0] dp;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      make_noise($urandom_range(1, 48));
    end else begin
      ver   = ($urandom_range(0, 9) != 0) ? IpVersion4 : 4'($urandom_range(0, 15));
      ihl   = ($urandom_range(0, 9) < 7) ? MinHdrWords : 4'($urandom_range(0, 15));
      proto = ($urandom_range(0, 9) != 0) ? ProtoTcp : 8'($urandom_range(0, 255));
      src   = ($urandom_range(0, 9) != 0) ? sb.src_addr : 32'($urandom);
      dp    = (sb.want_port != 0 && $urandom_range(0, 9) != 0) ? sb.want_port
                                                               : 16'($urandom_range(0, 65535));
      doff  = ($urandom_range(0, 9) < 7) ? MinHdrWords : 4'($urandom_range(0, 15));
      plen  = $urandom_range(0, 24);
      plant = -1;
      if ($urandom_range(0, 9) < 6) plant = $urandom_range(0, plen);
      cut = 0;
      if (kind < 35) cut = $urandom_range(1, 80);
      make_packet(ver, ihl, proto, src, dp, doff, plen, plant, cut);
    end
    send_packet();
  endtask

  // Register setting k: the first few are the extremes, the rest random.
  task automatic pick_setting(input int k);
    logic [15:0] port;
    logic [3:0]  plen;
    case (k)
      0: load_setting(32'h0, 16'h0, 1'b1, 64'h0, 4'd0);
      1: load_setting(32'hffff_ffff, 16'hffff, 1'b0, 64'hffff_ffff_ffff_ffff, 4'd8);
      2: load_setting($urandom, 16'h0, 1'b0, {$urandom, $urandom}, 4'd15);  // over capacity
      default: begin
        port = ($urandom_range(0, 9) < 3) ? 16'h0 : 16'($urandom_range(0, 65535));
        plen = ($urandom_range(0, 9) < 2) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 4));
        load_setting($urandom, port, ($urandom_range(0, 9) < 3), {$urandom, $urandom}, plen);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned set_bytes;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    packet_byte_i = '0;
    final_byte_i  = 1'b0;
    out_stall_i   = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    hold_request  = 1'b0;
    bytes_sent    = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: pattern 89 ab cd ef, port 443, pattern search on.
    load_setting(32'hc0a8_0101, 16'd443, 1'b0, 64'h0123_4567_89ab_cdef, 4'd4);
    // single-byte packets, all-ones and all-zeros byte
    make_noise(1); pkt_bytes[0] = 8'hff; send_packet();
    make_noise(1); pkt_bytes[0] = 8'h00; send_packet();
    // not TCP, caught at the protocol byte
    make_packet(IpVersion4, MinHdrWords, 8'd17, sb.src_addr, 16'd443, MinHdrWords, 0, -1, 10);
    send_packet();
    // version, protocol and source all wrong: lowest code wins
    make_packet(4'd6, MinHdrWords, 8'd17, 32'h0a00_0001, 16'd443, MinHdrWords, 0, -1, 16);
    send_packet();
    // short header length and short data offset, pattern present
    make_packet(IpVersion4, 4'd2, ProtoTcp, sb.src_addr, 16'd443, 4'd3, 6, 1, 0);
    send_packet();
    // ends inside the TCP header
    make_packet(IpVersion4, MinHdrWords, ProtoTcp, sb.src_addr, 16'd443, MinHdrWords, 0, -1, 30);
    send_packet();
    // payload shorter than the pattern: no match
    make_packet(IpVersion4, MinHdrWords, ProtoTcp, sb.src_addr, 16'd443, MinHdrWords, 3, 0, 0);
    send_packet();
    drain();

    // Random phases: sender/receiver idling 14/55, then 55/14, then none.
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 14 : (mode == 1) ? 55 : 0;
      recv_idle_pct = (mode == 0) ? 55 : (mode == 1) ? 14 : 0;
      for (int s = 0; s < 4; s++) begin
        pick_setting(mode * 4 + s);
        set_bytes = bytes_sent;
        while (bytes_sent - set_bytes < 45) random_packet();
        drain();
      end
    end

    // Receiver holds off while short packets keep arriving; the verdict
    // register fills and the input must stall.
    hold_request = 1'b1;
    repeat (30) begin
      make_noise($urandom_range(1, 6));
      send_packet();
    end
    drain();

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
